// ===== hw/rtl/dre_pkg.sv =====
package dre_pkg;

	localparam int unsigned MAX_PACKET_BYTES_DEF = 4096;

	// header length in bytes
	localparam int unsigned HDR_BYTES = 12;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_RUNT        = 3'd1;
	localparam logic [2:0] ST_BAD_QDCOUNT = 3'd2;
	localparam logic [2:0] ST_NO_ANSWERS  = 3'd3;
	localparam logic [2:0] ST_BAD_QTYPE   = 3'd4;
	localparam logic [2:0] ST_NOT_IPV4    = 3'd5;
	localparam logic [2:0] ST_NO_ADDRESS  = 3'd6;
	localparam logic [2:0] ST_TRUNCATED   = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] transaction_id;
		logic [31:0] ipv4_address;
	} out_item_t;

endpackage

// ===== hw/rtl/dns_response_address_extractor.sv =====
// Last byte path: input register, then output register, which drives out_valid.
// Throughput: one byte per cycle; a last byte waits in the input register only
// while a previous result is still held unread in the output register.
// Reset: arst_n (async, active low) clears the parser to the header phase and
// empties the input and output registers; the parser also rearms after each packet.
module dns_response_address_extractor #(
	parameter int unsigned MAX_PACKET_BYTES = dre_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dre_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dre_pkg::out_item_t out_data
);

	// input register: one byte transaction waiting for the parser
	logic              in_valid_s1;
	dre_pkg::in_item_t in_data_s1;

	// result register
	logic               out_valid_q;
	dre_pkg::out_item_t out_data_q;

	dre_pkg::out_item_t result;
	logic               advance;
	logic               out_free;

	// A byte that does not end the packet never needs the output slot, so
	// parsing keeps going while a result waits. Only a last byte stalls.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = in_valid_s1 && (!in_data_s1.packet_end || out_free);
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			in_data_s1 <= in_data;
	end

	// header fields, question skip, record walk and status all live here
	dre_parser #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (in_data_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && in_data_s1.packet_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_data_s1.packet_end)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	// a held result must block the next packet end in the input register
	a_last_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && in_data_s1.packet_end && out_valid_q && !out_ready) |-> !in_ready)
		else $error("last byte advanced over an unread result");

	// address is only reported with an ok status
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.status != dre_pkg::ST_OK) |-> (out_data_q.ipv4_address == 32'd0))
		else $error("nonzero address with error status");

	// every packet end that advances shows up as a result next cycle
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_data_s1.packet_end) |=> out_valid_q)
		else $error("packet end produced no result");
`endif

endmodule

// ===== hw/rtl/dre_parser.sv =====
// Per-byte parse state; next state and end-of-packet result are combinational from the current byte.
module dre_parser #(
	parameter int unsigned MAX_PACKET_BYTES = dre_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  dre_pkg::in_item_t  item,
	output dre_pkg::out_item_t result
);

	localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

	localparam logic [3:0] PH_HDR    = 4'd0;
	localparam logic [3:0] PH_QNAME  = 4'd1;
	localparam logic [3:0] PH_QTAIL  = 4'd2;
	localparam logic [3:0] PH_RNAME  = 4'd3;
	localparam logic [3:0] PH_LABELS = 4'd4;
	localparam logic [3:0] PH_PTR2   = 4'd5;
	localparam logic [3:0] PH_FIXED  = 4'd6;
	localparam logic [3:0] PH_SKIP   = 4'd7;
	localparam logic [3:0] PH_ADDR   = 4'd8;
	localparam logic [3:0] PH_DONE   = 4'd9;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_CNAME = 2'd1;
	localparam logic [1:0] KIND_A     = 2'd2;

	localparam logic [3:0] REC_GUARD = 4'd13;

	logic [3:0]       phase_q,  n_phase;
	logic [POS_W-1:0] pos_q,    n_pos;
	logic [3:0]       fc_q,     n_fc;
	logic [15:0]      id_q,     n_id;
	logic [15:0]      word_q,   n_word;
	logic [15:0]      skip_q,   n_skip;
	logic [31:0]      addr_q,   n_addr;
	logic [2:0]       early_q,  n_early;
	logic [3:0]       rec_q,    n_rec;
	logic [1:0]       kind_q,   n_kind;
	logic [2:0]       fin_status;

	always_comb begin
		n_phase = phase_q;
		n_pos   = pos_q;
		n_fc    = fc_q;
		n_id    = id_q;
		n_word  = word_q;
		n_skip  = skip_q;
		n_addr  = addr_q;
		n_early = early_q;
		n_rec   = rec_q;
		n_kind  = kind_q;

		if (pos_q < POS_W'(MAX_PACKET_BYTES)) begin
			n_pos = pos_q + POS_W'(1);
			if (phase_q >= PH_RNAME && phase_q <= PH_ADDR && rec_q < REC_GUARD)
				n_rec = rec_q + 4'd1;

			unique case (phase_q)
				PH_HDR: begin
					if (pos_q < POS_W'(2)) begin
						n_id = {id_q[7:0], item.data_byte};
					end else if (pos_q >= POS_W'(4) && pos_q <= POS_W'(7)) begin
						n_word = {word_q[7:0], item.data_byte};
						if (pos_q == POS_W'(5) && n_word != 16'd1) begin
							n_phase = PH_DONE;
							n_early = dre_pkg::ST_BAD_QDCOUNT;
						end else if (pos_q == POS_W'(7) && n_word == 16'd0) begin
							n_phase = PH_DONE;
							n_early = dre_pkg::ST_NO_ANSWERS;
						end
					end
					if (pos_q == POS_W'(dre_pkg::HDR_BYTES - 1) && n_phase == PH_HDR)
						n_phase = PH_QNAME;
				end
				PH_QNAME: begin
					if (item.data_byte == 8'd0) begin
						n_phase = PH_QTAIL;
						n_fc    = 4'd0;
					end
				end
				PH_QTAIL: begin
					n_fc = fc_q + 4'd1;
					if (n_fc <= 4'd2)
						n_word = {word_q[7:0], item.data_byte};
					if (n_fc == 4'd2 && n_word != 16'd1) begin
						n_phase = PH_DONE;
						n_early = dre_pkg::ST_BAD_QTYPE;
					end else if (n_fc == 4'd4) begin
						n_phase = PH_RNAME;
						n_rec   = 4'd0;
						n_fc    = 4'd0;
						n_kind  = KIND_NONE;
					end
				end
				PH_RNAME: begin
					if (item.data_byte == 8'hC0) begin
						n_phase = PH_PTR2;
					end else if (item.data_byte == 8'd0) begin
						n_phase = PH_FIXED;
						n_fc    = 4'd0;
					end else begin
						n_phase = PH_LABELS;
					end
				end
				PH_LABELS: begin
					if (item.data_byte == 8'd0) begin
						n_phase = PH_FIXED;
						n_fc    = 4'd0;
					end
				end
				PH_PTR2: begin
					n_phase = PH_FIXED;
					n_fc    = 4'd0;
				end
				PH_FIXED: begin
					n_fc = fc_q + 4'd1;
					if (n_fc <= 4'd2 || n_fc >= 4'd9)
						n_word = {word_q[7:0], item.data_byte};
					if (n_fc == 4'd2) begin
						if (n_word == 16'd5) begin
							n_kind = KIND_CNAME;
						end else if (n_word == 16'd1) begin
							n_kind = KIND_A;
						end else begin
							n_phase = PH_DONE;
							n_early = dre_pkg::ST_NO_ADDRESS;
						end
					end else if (n_fc == 4'd10) begin
						if (kind_q == KIND_CNAME) begin
							n_skip = n_word;
							if (n_word == 16'd0) begin
								n_phase = PH_RNAME;
								n_rec   = 4'd0;
								n_fc    = 4'd0;
								n_kind  = KIND_NONE;
							end else begin
								n_phase = PH_SKIP;
							end
						end else begin
							n_phase = PH_ADDR;
							n_fc    = 4'd0;
							n_addr  = 32'd0;
						end
					end
				end
				PH_SKIP: begin
					n_skip = skip_q - 16'd1;
					if (n_skip == 16'd0) begin
						n_phase = PH_RNAME;
						n_rec   = 4'd0;
						n_fc    = 4'd0;
						n_kind  = KIND_NONE;
					end
				end
				PH_ADDR: begin
					if (fc_q < 4'd4) begin
						n_addr = {addr_q[23:0], item.data_byte};
						n_fc   = fc_q + 4'd1;
					end
					if (n_rec >= REC_GUARD) begin
						if (word_q != 16'd4) begin
							n_phase = PH_DONE;
							n_early = dre_pkg::ST_NOT_IPV4;
						end else if (n_fc == 4'd4) begin
							n_phase = PH_DONE;
							n_early = dre_pkg::ST_OK;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// status as seen on the last byte, from the updated state
	always_comb begin
		if (n_pos < POS_W'(dre_pkg::HDR_BYTES)) begin
			fin_status = dre_pkg::ST_RUNT;
		end else begin
			case (n_phase) inside
				PH_DONE:            fin_status = n_early;
				PH_QNAME, PH_QTAIL: fin_status = dre_pkg::ST_BAD_QTYPE;
				PH_ADDR: begin
					if (n_fc == 4'd0 || n_rec < REC_GUARD)
						fin_status = dre_pkg::ST_NO_ADDRESS;
					else if (n_word != 16'd4)
						fin_status = dre_pkg::ST_NOT_IPV4;
					else
						fin_status = dre_pkg::ST_TRUNCATED;
				end
				default:            fin_status = dre_pkg::ST_NO_ADDRESS;
			endcase
		end
	end

	assign result.status         = fin_status;
	assign result.transaction_id = n_id;
	assign result.ipv4_address   = (fin_status == dre_pkg::ST_OK) ? n_addr : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= '0;
			fc_q    <= '0;
			id_q    <= '0;
			word_q  <= '0;
			skip_q  <= '0;
			addr_q  <= '0;
			early_q <= dre_pkg::ST_OK;
			rec_q   <= '0;
			kind_q  <= KIND_NONE;
		end else if (advance) begin
			if (item.packet_end) begin
				// rearm for the next packet
				phase_q <= PH_HDR;
				pos_q   <= '0;
				fc_q    <= '0;
				id_q    <= '0;
				word_q  <= '0;
				skip_q  <= '0;
				addr_q  <= '0;
				early_q <= dre_pkg::ST_OK;
				rec_q   <= '0;
				kind_q  <= KIND_NONE;
			end else begin
				phase_q <= n_phase;
				pos_q   <= n_pos;
				fc_q    <= n_fc;
				id_q    <= n_id;
				word_q  <= n_word;
				skip_q  <= n_skip;
				addr_q  <= n_addr;
				early_q <= n_early;
				rec_q   <= n_rec;
				kind_q  <= n_kind;
			end
		end
	end

endmodule

// ===== dv/dns_response_address_extractor_tb.sv =====
module dns_response_address_extractor_tb;

	localparam int MAX_BYTES = dre_pkg::MAX_PACKET_BYTES_DEF;

	// resource record and question types used by the generator
	localparam logic [15:0] RR_A     = 16'd1;
	localparam logic [15:0] RR_CNAME = 16'd5;
	localparam logic [15:0] RR_AAAA  = 16'd28;
	localparam logic [7:0]  NAME_PTR = 8'hC0;

	// long receiver hold-off, in cycles, forced at a couple of points in the run
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [3:0] {
		PH_HEADER, PH_QNAME, PH_QTAIL, PH_OWNER, PH_OWNER_LABELS,
		PH_OWNER_PTR, PH_RR_FIXED, PH_RR_SKIP, PH_ADDR, PH_DONE
	} parse_phase_t;

	typedef enum logic [1:0] {RK_NONE, RK_CNAME, RK_A} rr_kind_t;

	typedef enum int {OWN_POINTER, OWN_LABELS, OWN_ROOT} owner_form_t;

	typedef struct {
		dre_pkg::in_item_t item;
		bit                calm;		// no idle cycles after this byte
	} queued_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	dre_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	dre_pkg::out_item_t out_data;

	dns_response_address_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	queued_byte_t byte_stream[$];			// bytes waiting to be offered
	dre_pkg::out_item_t awaited_replies[$];		// predicted results, oldest first
	logic [7:0] pkt[$];			// packet under construction
	int mismatch_count = 0;

	// ------------------------------------------------------------------
	// Parser prediction. State mirrors the block; updated per accepted byte.
	// ------------------------------------------------------------------
	parse_phase_t p_phase;
	rr_kind_t p_kind;
	logic [12:0] p_pos;
	logic [3:0] p_fcount;
	logic [3:0] p_rr_bytes;		// saturates at 13
	logic [15:0] p_id;
	logic [15:0] p_word;
	logic [15:0] p_skip;
	logic [31:0] p_addr;
	logic [2:0] p_early;

	function automatic void clear_parser();
		p_phase = PH_HEADER;
		p_kind = RK_NONE;
		p_pos = '0;
		p_fcount = '0;
		p_rr_bytes = '0;
		p_id = '0;
		p_word = '0;
		p_skip = '0;
		p_addr = '0;
		p_early = dre_pkg::ST_OK;
	endfunction

	function automatic void conclude(input logic [2:0] st);
		p_phase = PH_DONE;
		p_early = st;
	endfunction

	function automatic void next_record();
		p_phase = PH_OWNER;
		p_rr_bytes = '0;
		p_fcount = '0;
		p_kind = RK_NONE;
	endfunction

	function automatic void parse_dns_byte(input dre_pkg::in_item_t it);
		logic [7:0] b;
		logic [2:0] st;
		dre_pkg::out_item_t r;
		b = it.data_byte;
		// bytes past the size limit are dropped, but packet_end still counts
		if (p_pos < MAX_BYTES) begin
			if (p_phase inside {PH_OWNER, PH_OWNER_LABELS, PH_OWNER_PTR, PH_RR_FIXED,
					PH_RR_SKIP, PH_ADDR} && p_rr_bytes < 13)
				p_rr_bytes++;
			case (p_phase)
				PH_HEADER: begin
					if (p_pos < 2) begin
						p_id = {p_id[7:0], b};
					end else if (p_pos >= 4 && p_pos <= 7) begin
						p_word = {p_word[7:0], b};
						// qdcount checked first, then ancount
						if (p_pos == 5 && p_word != 16'd1)
							conclude(dre_pkg::ST_BAD_QDCOUNT);
						else if (p_pos == 7 && p_word == 16'd0)
							conclude(dre_pkg::ST_NO_ANSWERS);
					end
					if (p_pos == dre_pkg::HDR_BYTES - 1 && p_phase == PH_HEADER)
						p_phase = PH_QNAME;
				end
				PH_QNAME: begin
					if (b == 8'd0) begin
						p_phase = PH_QTAIL;
						p_fcount = '0;
					end
				end
				PH_QTAIL: begin
					p_fcount++;
					if (p_fcount <= 2)
						p_word = {p_word[7:0], b};
					if (p_fcount == 2 && p_word != RR_A)
						conclude(dre_pkg::ST_BAD_QTYPE);
					else if (p_fcount == 4)
						next_record();
				end
				PH_OWNER: begin
					if (b == NAME_PTR) begin
						p_phase = PH_OWNER_PTR;
					end else if (b == 8'd0) begin
						p_phase = PH_RR_FIXED;
						p_fcount = '0;
					end else begin
						p_phase = PH_OWNER_LABELS;
					end
				end
				PH_OWNER_LABELS: begin
					if (b == 8'd0) begin
						p_phase = PH_RR_FIXED;
						p_fcount = '0;
					end
				end
				PH_OWNER_PTR: begin
					p_phase = PH_RR_FIXED;
					p_fcount = '0;
				end
				PH_RR_FIXED: begin
					// keep type (bytes 1-2) and rdlength (bytes 9-10)
					p_fcount++;
					if (p_fcount <= 2 || p_fcount >= 9)
						p_word = {p_word[7:0], b};
					if (p_fcount == 2) begin
						if (p_word == RR_CNAME)
							p_kind = RK_CNAME;
						else if (p_word == RR_A)
							p_kind = RK_A;
						else
							conclude(dre_pkg::ST_NO_ADDRESS);
					end else if (p_fcount == 10) begin
						if (p_kind == RK_CNAME) begin
							p_skip = p_word;
							if (p_skip == 16'd0)
								next_record();
							else
								p_phase = PH_RR_SKIP;
						end else begin
							p_phase = PH_ADDR;
							p_fcount = '0;
							p_addr = '0;
						end
					end
				end
				PH_RR_SKIP: begin
					p_skip--;
					if (p_skip == 16'd0)
						next_record();
				end
				PH_ADDR: begin
					if (p_fcount < 4) begin
						p_addr = {p_addr[23:0], b};
						p_fcount++;
					end
					// record guard: 13 record bytes before any address verdict
					if (p_rr_bytes >= 13) begin
						if (p_word != 16'd4)
							conclude(dre_pkg::ST_NOT_IPV4);
						else if (p_fcount == 4)
							conclude(dre_pkg::ST_OK);
					end
				end
				default: ;
			endcase
			p_pos++;
		end
		if (it.packet_end) begin
			if (p_pos < dre_pkg::HDR_BYTES) begin
				st = dre_pkg::ST_RUNT;
			end else begin
				case (p_phase)
					PH_DONE: st = p_early;
					PH_QNAME, PH_QTAIL: st = dre_pkg::ST_BAD_QTYPE;
					PH_ADDR: begin
						if (p_fcount == 0 || p_rr_bytes < 13)
							st = dre_pkg::ST_NO_ADDRESS;
						else if (p_word != 16'd4)
							st = dre_pkg::ST_NOT_IPV4;
						else
							st = dre_pkg::ST_TRUNCATED;
					end
					default: st = dre_pkg::ST_NO_ADDRESS;
				endcase
			end
			r.status = st;
			r.transaction_id = p_id;
			r.ipv4_address = (st == dre_pkg::ST_OK) ? p_addr : 32'd0;
			awaited_replies.push_back(r);
			clear_parser();
		end
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// ------------------------------------------------------------------
	// Packet builders
	// ------------------------------------------------------------------
	task automatic put_word(input logic [15:0] w);
		pkt.push_back(w[15:8]);
		pkt.push_back(w[7:0]);
	endtask

	task automatic put_random(input int n);
		repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
	endtask

	// n labels of 1..5 nonzero bytes, then the root byte
	task automatic put_labels(input int n);
		int len;
		repeat (n) begin
			len = $urandom_range(1, 5);
			pkt.push_back(8'(len));
			repeat (len) pkt.push_back(8'($urandom_range(1, 255)));
		end
		pkt.push_back(8'd0);
	endtask

	task automatic put_header(input logic [15:0] id, input logic [15:0] qd,
			input logic [15:0] an);
		put_word(id);
		put_word(16'($urandom));		// flags
		put_word(qd);
		put_word(an);
		put_word(16'($urandom));		// nscount
		put_word(16'($urandom));		// arcount
	endtask

	task automatic put_question(input logic [15:0] qtype, input int nlabels);
		put_labels(nlabels);
		put_word(qtype);
		put_word(16'($urandom));		// qclass
	endtask

	// owner name plus the ten fixed bytes; rdata is added by the caller
	task automatic put_record(input owner_form_t owner, input logic [15:0] rtype,
			input logic [15:0] dlen);
		case (owner)
			OWN_POINTER: begin
				pkt.push_back(NAME_PTR);
				pkt.push_back(8'($urandom_range(0, 255)));
			end
			OWN_LABELS: put_labels($urandom_range(1, 3));
			default: pkt.push_back(8'd0);
		endcase
		put_word(rtype);
		put_word(16'($urandom));		// class
		put_word(16'($urandom));		// ttl
		put_word(16'($urandom));
		put_word(dlen);
	endtask

	task automatic cut_to(input int n);
		while (pkt.size() > n)
			void'(pkt.pop_back());
	endtask

	task automatic ship(input bit calm);
		queued_byte_t q;
		foreach (pkt[i]) begin
			q.item.data_byte = pkt[i];
			q.item.packet_end = (i == pkt.size() - 1);
			q.calm = calm;
			byte_stream.push_back(q);
		end
		pkt.delete();
	endtask

	// Mostly well-formed responses with random content; some noise and
	// damaged ones (bad counts, bad qtype, odd lengths, cut or padded).
	task automatic random_response();
		int r;
		logic [15:0] dlen;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			put_random($urandom_range(1, 40));
		end else begin
			put_header(16'($urandom), (r < 10) ? 16'($urandom) : 16'd1,
				(r < 15) ? 16'd0 : 16'($urandom_range(1, 65535)));
			put_question(($urandom_range(0, 19) == 0) ? 16'($urandom) : RR_A,
				$urandom_range(0, 3));
			repeat ($urandom_range(0, 2)) begin
				dlen = 16'($urandom_range(0, 12));
				put_record(owner_form_t'($urandom_range(0, 2)), RR_CNAME, dlen);
				put_random(dlen);
			end
			if ($urandom_range(0, 99) < 75) begin
				dlen = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 8)) : 16'd4;
				put_record(owner_form_t'($urandom_range(0, 2)), RR_A, dlen);
			end else begin
				dlen = 16'($urandom_range(0, 6));
				put_record(owner_form_t'($urandom_range(0, 2)), 16'($urandom), dlen);
			end
			put_random(dlen);
			if ($urandom_range(0, 6) == 0)
				cut_to($urandom_range(1, pkt.size()));
			else if ($urandom_range(0, 4) == 0)
				put_random($urandom_range(1, 6));
		end
		ship($urandom_range(0, 3) == 0);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued bytes, predicts each accepted transaction
	// ------------------------------------------------------------------
	int send_gap;
	queued_byte_t next_byte;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				parse_dns_byte(in_data);
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (byte_stream.size() != 0) begin
				next_byte = byte_stream.pop_front();
				in_data <= next_byte.item;
				in_valid <= 1'b1;
				send_gap <= next_byte.calm ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure, two long hold-offs, result checks
	// ------------------------------------------------------------------
	int recv_gap;
	int hold_left;
	int results_seen = 0;
	dre_pkg::out_item_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_replies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: status %0d id %h addr %h",
							out_data.status, out_data.transaction_id,
							out_data.ipv4_address);
				end else begin
					want = awaited_replies.pop_front();
					if (out_data.status !== want.status ||
							out_data.transaction_id !== want.transaction_id ||
							out_data.ipv4_address !== want.ipv4_address) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result %0d: expected status %0d id %h addr %h,",
								" got status %0d id %h addr %h"},
								results_seen, want.status, want.transaction_id,
								want.ipv4_address, out_data.status,
								out_data.transaction_id, out_data.ipv4_address);
					end
				end
			end
			// long hold-off: sender keeps going so the block backs up into its input
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready &&
					(results_seen == 8 || results_seen == 20)) begin
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				// some stretches are always ready
				if (results_seen % 10 >= 3 && $urandom_range(0, 3) == 0)
					recv_gap <= pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int npk;

		// clean A answer, compressed owner, all-ones id and address
		put_header(16'hFFFF, 16'd1, 16'd1);
		put_question(RR_A, 2);
		put_record(OWN_POINTER, RR_A, 16'd4);
		repeat (4) pkt.push_back(8'hFF);
		ship(1'b0);
		// all-zero id and address, uncompressed owner, root qname
		put_header(16'h0000, 16'd1, 16'hFFFF);
		put_question(RR_A, 0);
		put_record(OWN_LABELS, RR_A, 16'd4);
		repeat (4) pkt.push_back(8'h00);
		ship(1'b0);
		// empty CNAME, CNAME with data, then A with root owner and trailing bytes
		put_header(16'($urandom), 16'd1, 16'd3);
		put_question(RR_A, 1);
		put_record(OWN_ROOT, RR_CNAME, 16'd0);
		put_record(OWN_POINTER, RR_CNAME, 16'd3);
		put_random(3);
		put_record(OWN_ROOT, RR_A, 16'd4);
		put_random(9);
		ship(1'b0);
		// runts: one byte, eleven bytes
		put_random(1);
		ship(1'b0);
		put_header(16'($urandom), 16'd1, 16'd1);
		cut_to(11);
		ship(1'b0);
		// header only: question cut short
		put_header(16'($urandom), 16'd1, 16'd1);
		ship(1'b0);
		// bad qdcount wins over zero ancount
		put_header(16'($urandom), 16'd0, 16'd0);
		put_question(RR_A, 1);
		ship(1'b0);
		put_header(16'($urandom), 16'd2, 16'd1);
		put_question(RR_A, 1);
		put_record(OWN_POINTER, RR_A, 16'd4);
		put_random(4);
		ship(1'b0);
		// no answers
		put_header(16'($urandom), 16'd1, 16'd0);
		put_question(RR_A, 1);
		ship(1'b0);
		// wrong qtype
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_AAAA, 1);
		put_record(OWN_POINTER, RR_A, 16'd4);
		put_random(4);
		ship(1'b0);
		// question cut inside the name, then inside qtype/qclass
		put_header(16'($urandom), 16'd1, 16'd1);
		put_labels(2);
		cut_to(14);
		ship(1'b0);
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 0);
		cut_to(16);
		ship(1'b0);
		// ends right after the question
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 1);
		ship(1'b0);
		// first record neither A nor CNAME
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 1);
		put_record(OWN_POINTER, RR_AAAA, 16'd16);
		put_random(16);
		ship(1'b0);
		// A with bad length
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 1);
		put_record(OWN_POINTER, RR_A, 16'd16);
		put_random(16);
		ship(1'b0);
		// address cut short
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 1);
		put_record(OWN_POINTER, RR_A, 16'd4);
		put_random(2);
		ship(1'b0);
		// record guard not met: root owner, one data byte
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 1);
		put_record(OWN_ROOT, RR_A, 16'd2);
		put_random(1);
		ship(1'b0);
		// root owner, bad length, guard just met
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 1);
		put_record(OWN_ROOT, RR_A, 16'd5);
		put_random(2);
		ship(1'b0);
		// A with no data bytes at all
		put_header(16'($urandom), 16'd1, 16'd1);
		put_question(RR_A, 1);
		put_record(OWN_POINTER, RR_A, 16'd4);
		ship(1'b0);
		// records cut short: inside CNAME data, inside fixed fields
		put_header(16'($urandom), 16'd1, 16'd2);
		put_question(RR_A, 1);
		put_record(OWN_LABELS, RR_CNAME, 16'd10);
		put_random(4);
		ship(1'b0);
		put_header(16'($urandom), 16'd1, 16'd2);
		put_question(RR_A, 1);
		put_record(OWN_POINTER, RR_CNAME, 16'd2);
		cut_to(pkt.size() - 3);
		ship(1'b0);

		// random responses until the run holds about 550 bytes
		npk = 0;
		while (byte_stream.size() < 550 || npk < 3) begin
			random_response();
			npk++;
		end

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (byte_stream.size() != 0 || in_valid || awaited_replies.size() != 0);
		// let any stray result show up
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && awaited_replies.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#6000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/dre_pkg.sv
hw/rtl/dre_parser.sv
hw/rtl/dns_response_address_extractor.sv
dv/dns_response_address_extractor_tb.sv
